// ===== rtl/crc8_frame_deframer_key_events_assert.svh =====
// Assertion macros used by the checker file of the deframer.
`ifndef CRC8_FRAME_DEFRAMER_KEY_EVENTS_ASSERT_SVH
`define CRC8_FRAME_DEFRAMER_KEY_EVENTS_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define C8DK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("c8dk: implication check failed");

// Antecedent implies consequent in the following cycle.
`define C8DK_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("c8dk: next-cycle check failed");

`endif

// ===== rtl/c8dk_pkg.sv =====
`default_nettype none
package c8dk_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_SYNC_FIRST  = 3'd0;
    localparam logic [2:0] CFG_SYNC_SECOND = 3'd1;
    localparam logic [2:0] CFG_EXP_VERSION = 3'd2;
    localparam logic [2:0] CFG_MAX_PAYLOAD = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT     = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  RST_SYNC_FIRST  = 8'hA5;
    localparam logic [7:0]  RST_SYNC_SECOND = 8'h5A;
    localparam logic [7:0]  RST_EXP_VERSION = 8'd1;
    localparam logic [5:0]  RST_MAX_PAYLOAD = 6'd32;
    localparam logic [15:0] RST_TIMEOUT     = 16'd200;

    // Frame and key constants
    localparam logic [7:0]  CRC_POLY     = 8'h07;
    localparam logic [7:0]  FT_KEY_EVENT = 8'd1;
    localparam logic [7:0]  FT_KEY_STATE = 8'd2;
    localparam logic [7:0]  PRESS_CODE   = 8'd1;
    localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [7:0]  CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0]  CASE_OFFSET  = 8'd32;
    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam logic [15:0] SILENCE_MAX  = 16'hFFFF;

    // Key-state frames cover keys '0'..'7'
    localparam int          STATE_KEYS = 8;
    localparam int          KIDX_W     = $clog2(STATE_KEYS);

    // Command queue between front and back
    localparam int          QDEPTH = 4;
    localparam int          QPTR_W = $clog2(QDEPTH);
    localparam int          QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_RELALL  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CMD_KEY    = 2'd0,
        CMD_STATE  = 2'd1,
        CMD_RELALL = 2'd2
    } t_cmd_kind;

    // One queued command; for a key-state frame key holds payload byte zero
    typedef struct packed {
        t_cmd_kind  kind;
        t_action    action;
        logic [7:0] key;
    } t_cmd;

    // Configuration write bundle
    typedef struct packed {
        logic        we;
        logic [2:0]  idx;
        logic [15:0] data;
    } t_cfg_wr;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // One CRC-8 byte step, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/crc8_frame_deframer_key_events.sv =====
// Results pass the command queue and the back-end command register into the output register.
// Throughput: one input transaction per cycle while the 4-entry command queue has room;
// the back end gives one result per cycle unless stalled; a key-state frame gives 8 results.
// Reset: synchronous, active low; clears parser, silence count, queue and output valid,
// and loads the configuration registers with their defaults.
`default_nettype none
module crc8_frame_deframer_key_events (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    // Input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] byte_value
    input  wire logic [0:0]  i_s_tuser,   // [0] kind
    // Output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [1:0] action, [9:2] key_code, [15:10] zero
    output logic             o_m_tlast    // last
);
    import c8dk_pkg::*;

    t_cfg_wr    cfg;
    t_q_stat    q_stat;
    t_cmd       push_cmd, head_cmd;
    logic       push, pop;
    logic [1:0] action;
    logic [7:0] key_code;

    assign cfg = '{we: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};

    c8dk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_kind   (i_s_tuser[0]),
        .i_byte   (i_s_tdata),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    c8dk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    c8dk_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_cmd    (head_cmd),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_action (action),
        .o_key    (key_code),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {6'b000000, key_code, action};

endmodule
`default_nettype wire

// ===== rtl/c8dk_queue.sv =====
`default_nettype none
module c8dk_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire c8dk_pkg::t_cmd  i_cmd,
    input  wire logic            i_pop,
    output c8dk_pkg::t_cmd       o_cmd,
    output c8dk_pkg::t_q_stat    o_stat
);
    import c8dk_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rp];

    // Advance pointers and count
    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store entry payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/c8dk_front.sv =====
`default_nettype none
module c8dk_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire c8dk_pkg::t_cfg_wr i_cfg,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_kind,
    input  wire logic [7:0]        i_byte,
    input  wire c8dk_pkg::t_q_stat i_q_stat,
    output logic                   o_push,
    output c8dk_pkg::t_cmd         o_cmd
);
    import c8dk_pkg::*;

    typedef enum logic [4:0] {
        PH_SYNC1   = 5'b00001,
        PH_SYNC2   = 5'b00010,
        PH_HEADER  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CRC     = 5'b10000
    } t_phase;

    // Configuration registers
    logic [7:0]  r_sync1, r_sync2, r_exp_ver;
    logic [5:0]  r_max_len;
    logic [15:0] r_timeout;

    // Parser and timeout state
    t_phase      r_phase, n_phase;
    logic [5:0]  r_pos, n_pos;
    logic [5:0]  r_len, n_len;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_ver, n_ver;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_b0, n_b0;
    logic [7:0]  r_b1, n_b1;
    logic [15:0] r_sil, n_sil;
    logic        r_held, n_held;

    logic        accept;
    logic [7:0]  crc_next;
    logic [5:0]  pos_inc;
    logic [7:0]  key_fold;

    assign o_ready  = !i_q_stat.full;
    assign accept   = i_valid && o_ready;
    assign crc_next = crc8_step(r_crc, i_byte);
    assign pos_inc  = r_pos + 1'b1;
    assign key_fold = (r_b0 >= CHAR_UPPER_A && r_b0 <= CHAR_UPPER_Z) ? r_b0 + CASE_OFFSET
                                                                     : r_b0;

    // Classify the transaction and update parser state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_len   = r_len;
        n_crc   = r_crc;
        n_ver   = r_ver;
        n_type  = r_type;
        n_b0    = r_b0;
        n_b1    = r_b1;
        n_sil   = r_sil;
        n_held  = r_held;
        o_push  = 1'b0;
        o_cmd   = '{kind: CMD_RELALL, action: ACT_RELALL, key: 8'd0};
        if (accept) begin
            if (i_kind) begin
                // Millisecond tick: count silence, release held keys on timeout
                n_sil = (r_sil == SILENCE_MAX) ? r_sil : r_sil + 1'b1;
                if (r_held && n_sil > r_timeout) begin
                    o_push = 1'b1;
                    n_held = 1'b0;
                end
            end else begin
                n_sil = '0;
                unique case (r_phase)
                    PH_SYNC2: begin
                        if (i_byte == r_sync2) begin
                            n_phase = PH_HEADER;
                            n_pos   = '0;
                            n_crc   = '0;
                        end else begin
                            n_phase = PH_SYNC1;
                        end
                    end
                    PH_HEADER: begin
                        n_crc = crc_next;
                        if (r_pos == 6'd0) begin
                            n_ver = i_byte;
                        end else if (r_pos == 6'd1) begin
                            n_type = i_byte;
                        end
                        if (r_pos == 6'd4) begin
                            n_pos = '0;
                            if (i_byte > {2'b00, r_max_len}) begin
                                n_phase = PH_SYNC1;
                            end else begin
                                n_len   = i_byte[5:0];
                                n_phase = (i_byte[5:0] == 6'd0) ? PH_CRC : PH_PAYLOAD;
                            end
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_crc = crc_next;
                        if (r_pos == 6'd0) begin
                            n_b0 = i_byte;
                        end else if (r_pos == 6'd1) begin
                            n_b1 = i_byte;
                        end
                        n_pos = pos_inc;
                        if (pos_inc == r_len || pos_inc == 6'd0) begin
                            n_phase = PH_CRC;
                        end
                    end
                    PH_CRC: begin
                        // Frame end: check CRC, version and payload length
                        n_phase = PH_SYNC1;
                        if (i_byte == r_crc && r_ver == r_exp_ver && r_len >= 6'd2) begin
                            if (r_type == FT_KEY_EVENT) begin
                                o_push     = 1'b1;
                                o_cmd.kind = CMD_KEY;
                                o_cmd.action = (r_b1 == PRESS_CODE) ? ACT_PRESS : ACT_RELEASE;
                                o_cmd.key  = key_fold;
                                n_held     = 1'b1;
                            end else if (r_type == FT_KEY_STATE) begin
                                o_push       = 1'b1;
                                o_cmd.kind   = CMD_STATE;
                                o_cmd.action = ACT_PRESS;
                                o_cmd.key    = r_b0;
                                n_held       = |(r_b0 | r_b1);
                            end
                        end
                    end
                    default: begin
                        // Hunt the first sync byte
                        n_phase = (i_byte == r_sync1) ? PH_SYNC2 : PH_SYNC1;
                    end
                endcase
            end
        end
    end

    // Parser control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_pos   <= '0;
            r_len   <= '0;
            r_crc   <= '0;
            r_ver   <= '0;
            r_type  <= '0;
            r_b0    <= '0;
            r_b1    <= '0;
            r_sil   <= '0;
            r_held  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_ver   <= n_ver;
            r_type  <= n_type;
            r_b0    <= n_b0;
            r_b1    <= n_b1;
            r_sil   <= n_sil;
            r_held  <= n_held;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync1   <= RST_SYNC_FIRST;
            r_sync2   <= RST_SYNC_SECOND;
            r_exp_ver <= RST_EXP_VERSION;
            r_max_len <= RST_MAX_PAYLOAD;
            r_timeout <= RST_TIMEOUT;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_SYNC_FIRST:  r_sync1   <= i_cfg.data[7:0];
                CFG_SYNC_SECOND: r_sync2   <= i_cfg.data[7:0];
                CFG_EXP_VERSION: r_exp_ver <= i_cfg.data[7:0];
                CFG_MAX_PAYLOAD: r_max_len <= i_cfg.data[5:0];
                CFG_TIMEOUT:     r_timeout <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/c8dk_back.sv =====
`default_nettype none
module c8dk_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire c8dk_pkg::t_q_stat i_q_stat,
    input  wire c8dk_pkg::t_cmd    i_cmd,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_action,
    output logic [7:0]             o_key,
    output logic                   o_last
);
    import c8dk_pkg::*;

    logic              r_busy, n_busy;
    t_cmd              r_cmd, n_cmd;
    logic [KIDX_W-1:0] r_idx, n_idx;
    logic              r_ovalid, n_ovalid;
    t_action           r_act, n_act;
    logic [7:0]        r_key, n_key;
    logic              r_last, n_last;

    t_action           g_act;
    logic [7:0]        g_key;
    logic              g_last;
    logic              load;

    // Form the next result of the current command
    always_comb begin
        unique case (r_cmd.kind)
            CMD_KEY: begin
                g_act  = r_cmd.action;
                g_key  = r_cmd.key;
                g_last = 1'b1;
            end
            CMD_STATE: begin
                g_act  = r_cmd.key[r_idx] ? ACT_PRESS : ACT_RELEASE;
                g_key  = CHAR_ZERO + 8'(r_idx);
                g_last = (r_idx == KIDX_W'(STATE_KEYS - 1));
            end
            default: begin
                g_act  = ACT_RELALL;
                g_key  = 8'd0;
                g_last = 1'b1;
            end
        endcase
    end

    assign load  = r_busy && (!r_ovalid || i_ready);
    assign o_pop = !i_q_stat.empty && (!r_busy || (load && g_last));

    // Sequence commands and hold the output register
    always_comb begin
        n_busy   = r_busy;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        n_act    = r_act;
        n_key    = r_key;
        n_last   = r_last;
        if (o_pop) begin
            n_busy = 1'b1;
            n_cmd  = i_cmd;
            n_idx  = '0;
        end else if (load && g_last) begin
            n_busy = 1'b0;
        end else if (load) begin
            n_idx = r_idx + 1'b1;
        end
        if (load) begin
            n_ovalid = 1'b1;
            n_act    = g_act;
            n_key    = g_key;
            n_last   = g_last;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
            r_idx    <= n_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_act  <= n_act;
        r_key  <= n_key;
        r_last <= n_last;
    end

    assign o_valid  = r_ovalid;
    assign o_action = r_act;
    assign o_key    = r_key;
    assign o_last   = r_last;

endmodule
`default_nettype wire

// ===== rtl/c8dk_checker.sv =====
`default_nettype none
`include "crc8_frame_deframer_key_events_assert.svh"
module c8dk_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata,
    input wire logic        o_m_tlast
);
    import c8dk_pkg::*;

    // A stalled result holds
    `C8DK_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    // Action code is one of press, release, release all
    `C8DK_ASSERT_IMP(a_action_code, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[1:0] != 2'd3)

    // Release all carries key code zero and closes its item
    `C8DK_ASSERT_IMP(a_relall_form, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[1:0] == ACT_RELALL), (o_m_tdata[9:2] == 8'd0) && o_m_tlast)

    // Padding bits stay zero
    `C8DK_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[15:10] == 6'd0)

endmodule

bind crc8_frame_deframer_key_events c8dk_checker u_c8dk_checker (.*);
`default_nettype wire

// ===== dv/crc8_frame_deframer_key_events_tb.sv =====
`timescale 1ns / 100ps
module crc8_frame_deframer_key_events_tb;
    import c8dk_pkg::*;

    localparam logic       KIND_BYTE   = 1'b0;
    localparam logic       KIND_TICK   = 1'b1;
    localparam logic [5:0] HDR_VERSION = 6'd0;
    localparam logic [5:0] HDR_TYPE    = 6'd1;
    localparam logic [5:0] HDR_LENGTH  = 6'd4;
    localparam int         HDR_BYTES   = 5;
    localparam int         DRAIN_CYCLES = 12;

    typedef enum logic [4:0] {
        SEEK_FIRST  = 5'b00001,
        SEEK_SECOND = 5'b00010,
        TAKE_HEADER = 5'b00100,
        TAKE_BODY   = 5'b01000,
        TAKE_CHECK  = 5'b10000
    } t_parse_state;

    typedef struct packed {
        t_action    action;
        logic [7:0] key;
        logic       last;
    } t_key_event;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = '0;   // [7:0] byte_value
    logic [0:0]  i_s_tuser  = '0;   // [0] kind
    logic        i_m_tready = 1'b0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [15:0] o_m_tdata;         // [1:0] action, [9:2] key_code, [15:10] zero
    wire         o_m_tlast;         // last

    crc8_frame_deframer_key_events DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Shadow configuration
    logic [7:0]   cfg_sync_first;
    logic [7:0]   cfg_sync_second;
    logic [7:0]   cfg_version;
    logic [5:0]   cfg_max_payload;
    logic [15:0]  cfg_timeout;

    // Shadow deframer state
    t_parse_state dfm_state;
    logic [5:0]   dfm_pos;
    logic [5:0]   dfm_len;
    logic [7:0]   dfm_crc;
    logic [7:0]   dfm_version;
    logic [7:0]   dfm_type;
    logic [7:0]   dfm_pay0;
    logic [7:0]   dfm_pay1;
    logic [15:0]  silence_ms;
    logic         keys_held;

    t_key_event   pending_key_events[$];
    int           mismatches     = 0;
    bit           no_idle        = 1'b0;
    bit           mix_ticks      = 1'b0;
    int           stall_left     = 0;

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // CRC-8, poly 0x07, MSB first
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
        return c;
    endfunction

    task automatic queue_key_event(input t_action act, input logic [7:0] key);
        t_key_event ev;
        ev.action = act;
        ev.key    = key;
        ev.last   = 1'b0;
        pending_key_events.push_back(ev);
    endtask

    // Advance the shadow deframer by one accepted transaction
    task automatic predict_key_events(input logic kind, input logic [7:0] b);
        int         n0;
        logic [7:0] key;
        logic [7:0] bit_i;
        t_key_event ev;
        n0 = pending_key_events.size();
        if (kind == KIND_TICK) begin
            if (silence_ms != SILENCE_MAX) silence_ms++;
            if (keys_held && silence_ms > cfg_timeout) begin
                queue_key_event(ACT_RELALL, 8'h00);
                keys_held = 1'b0;
            end
        end else begin
            silence_ms = '0;
            case (dfm_state)
                SEEK_SECOND: begin
                    if (b == cfg_sync_second) begin
                        dfm_state = TAKE_HEADER;
                        dfm_pos   = '0;
                        dfm_crc   = '0;
                    end else begin
                        dfm_state = SEEK_FIRST;
                    end
                end
                TAKE_HEADER: begin
                    dfm_crc = crc8_next(dfm_crc, b);
                    if (dfm_pos == HDR_VERSION) dfm_version = b;
                    else if (dfm_pos == HDR_TYPE) dfm_type = b;
                    if (dfm_pos == HDR_LENGTH) begin
                        dfm_pos = '0;
                        if (b > {2'b00, cfg_max_payload}) begin
                            dfm_state = SEEK_FIRST;
                        end else begin
                            dfm_len   = b[5:0];
                            dfm_state = (dfm_len == 0) ? TAKE_CHECK : TAKE_BODY;
                        end
                    end else begin
                        dfm_pos = dfm_pos + 1'b1;
                    end
                end
                TAKE_BODY: begin
                    dfm_crc = crc8_next(dfm_crc, b);
                    if (dfm_pos == 0) dfm_pay0 = b;
                    else if (dfm_pos == 1) dfm_pay1 = b;
                    dfm_pos = dfm_pos + 1'b1;
                    if (dfm_pos == dfm_len || dfm_pos == 0) dfm_state = TAKE_CHECK;
                end
                TAKE_CHECK: begin
                    // Accept only a clean frame with at least two payload bytes
                    if (b == dfm_crc && dfm_version == cfg_version && dfm_len >= 2) begin
                        if (dfm_type == FT_KEY_EVENT) begin
                            key = dfm_pay0;
                            if (key >= CHAR_UPPER_A && key <= CHAR_UPPER_Z) key = key + CASE_OFFSET;
                            queue_key_event(dfm_pay1 == PRESS_CODE ? ACT_PRESS : ACT_RELEASE, key);
                            keys_held = 1'b1;
                        end else if (dfm_type == FT_KEY_STATE) begin
                            for (bit_i = 0; bit_i < STATE_KEYS; bit_i++) begin
                                queue_key_event(dfm_pay0[bit_i[2:0]] ? ACT_PRESS : ACT_RELEASE,
                                                CHAR_ZERO + bit_i);
                            end
                            keys_held = |{dfm_pay0, dfm_pay1};
                        end
                    end
                    dfm_state = SEEK_FIRST;
                end
                default: begin
                    dfm_state = (b == cfg_sync_first) ? SEEK_SECOND : SEEK_FIRST;
                end
            endcase
        end
        // Mark the final event of this transaction
        if (pending_key_events.size() > n0) begin
            ev = pending_key_events.pop_back();
            ev.last = 1'b1;
            pending_key_events.push_back(ev);
        end
    endtask

    // Drive one transaction and wait for the handshake
    task automatic send_item(input logic kind, input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser  = kind;
        i_s_tdata  = b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_key_events(kind, b);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(KIND_TICK, 8'($urandom));
    endtask

    // Optionally slip a tick in ahead of a frame byte
    task automatic drive_packet_byte(input logic [7:0] b);
        if (mix_ticks && $urandom_range(0, 19) == 0) send_item(KIND_TICK, 8'($urandom));
        send_item(KIND_BYTE, b);
    endtask

    // Send sync, header, payload and CRC; an oversize length stops after the header
    task automatic drive_packet(input logic [7:0] ver, input logic [7:0] ftype,
                                input logic [7:0] len_byte, input logic [7:0] b0,
                                input logic [7:0] b1, input logic [7:0] crc_flip);
        logic [7:0] hdr [0:HDR_BYTES-1];
        logic [7:0] pay;
        logic [7:0] crc;
        int         n;
        hdr[0] = ver;
        hdr[1] = ftype;
        hdr[2] = 8'($urandom);
        hdr[3] = 8'($urandom);
        hdr[4] = len_byte;
        crc    = '0;
        drive_packet_byte(cfg_sync_first);
        drive_packet_byte(cfg_sync_second);
        for (n = 0; n < HDR_BYTES; n++) begin
            crc = crc8_next(crc, hdr[n]);
            drive_packet_byte(hdr[n]);
        end
        if (len_byte <= {2'b00, cfg_max_payload}) begin
            for (n = 0; n < len_byte; n++) begin
                pay = (n == 0) ? b0 : (n == 1) ? b1 : 8'($urandom);
                crc = crc8_next(crc, pay);
                drive_packet_byte(pay);
            end
            drive_packet_byte(crc ^ crc_flip);
        end
    endtask

    // Drop valid, let all expected events arrive, then let the pipeline settle
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_key_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        case (idx)
            CFG_SYNC_FIRST:  cfg_sync_first  = val[7:0];
            CFG_SYNC_SECOND: cfg_sync_second = val[7:0];
            CFG_EXP_VERSION: cfg_version     = val[7:0];
            CFG_MAX_PAYLOAD: cfg_max_payload = val[5:0];
            CFG_TIMEOUT:     cfg_timeout     = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] ver,
                             input logic [5:0] maxp, input logic [15:0] tmo);
        write_reg(CFG_SYNC_FIRST, {8'h00, s1});
        write_reg(CFG_SYNC_SECOND, {8'h00, s2});
        write_reg(CFG_EXP_VERSION, {8'h00, ver});
        write_reg(CFG_MAX_PAYLOAD, {10'h000, maxp});
        write_reg(CFG_TIMEOUT, tmo);
    endtask

    // Press and release events, with case folding at the letter borders
    task automatic test_key_events();
        drive_packet(cfg_version, FT_KEY_EVENT, 8'd2, "A", PRESS_CODE, 8'h00);
        drive_packet(cfg_version, FT_KEY_EVENT, 8'd2, "Z", 8'h00, 8'h00);
        drive_packet(cfg_version, FT_KEY_EVENT, 8'd2, 8'h5B, 8'h02, 8'h00);
        wait_drained();
    endtask

    // Eight-key state frame
    task automatic test_key_state();
        drive_packet(cfg_version, FT_KEY_STATE, 8'd3, 8'hA5, 8'h00, 8'h00);
        wait_drained();
    endtask

    // Frames that must be consumed silently, then recovery
    task automatic test_rejected_frames();
        drive_packet(cfg_version, FT_KEY_EVENT, 8'd2, "q", PRESS_CODE, 8'h01);
        drive_packet(cfg_version, FT_KEY_EVENT, 8'd33, "u", PRESS_CODE, 8'h00);
        drive_packet(cfg_version, FT_KEY_EVENT, 8'd1, "y", PRESS_CODE, 8'h00);
        // bad second sync byte returns to the hunt
        send_item(KIND_BYTE, cfg_sync_first);
        send_item(KIND_BYTE, 8'h00);
        drive_packet(cfg_version, FT_KEY_EVENT, 8'd2, "o", PRESS_CODE, 8'h00);
        wait_drained();
    endtask

    // Release-all after silence
    task automatic test_release_timeout();
        write_all(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_EXP_VERSION, RST_MAX_PAYLOAD, 16'd3);
        drive_packet(cfg_version, FT_KEY_EVENT, 8'd2, "k", PRESS_CODE, 8'h00);
        send_ticks(5);
        wait_drained();
    endtask

    // Register extremes for sync, version and timeout
    task automatic test_config_extremes();
        write_all(8'h00, 8'hFF, 8'hFF, 6'd2, 16'hFFFF);
        drive_packet(cfg_version, FT_KEY_STATE, 8'd2, 8'h96, 8'h00, 8'h00);
        wait_drained();
    endtask

    // Random configuration with mostly well-formed frames
    task automatic test_random_traffic();
        int         r;
        logic [7:0] ftype;
        logic [7:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        write_all(8'($urandom), 8'($urandom), 8'($urandom), 6'($urandom_range(2, 63)),
                  16'($urandom_range(0, 20)));
        no_idle   = ($urandom_range(0, 3) == 0);
        mix_ticks = 1'b1;
        repeat (3) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                r     = $urandom_range(0, 99);
                ftype = (r < 45) ? FT_KEY_EVENT : (r < 85) ? FT_KEY_STATE : 8'($urandom);
                len   = 8'($urandom_range(2, 3));
                b0 = $urandom_range(0, 1) ? 8'($urandom_range(8'h40, 8'h5B)) : 8'($urandom);
                b1 = $urandom_range(0, 1) ? PRESS_CODE : 8'($urandom);
                drive_packet(cfg_version, ftype, len, b0, b1, 8'h00);
            end else begin
                send_ticks($urandom_range(1, 4));
            end
        end
        mix_ticks = 1'b0;
        no_idle   = 1'b0;
        wait_drained();
    endtask

    // Output backpressure: random stalls of random length
    always @(negedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            i_m_tready = 1'b1;
        end else if (stall_left > 0) begin
            i_m_tready = 1'b0;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            i_m_tready = (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Compare each output transaction with the oldest expected key event
    always @(posedge i_clk) begin : check_key_events
        t_key_event  want;
        logic [15:0] want_tdata;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_key_events.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual tdata=%h tlast=%b",
                         $time, o_m_tdata, o_m_tlast);
                mismatches++;
            end else begin
                want       = pending_key_events.pop_front();
                want_tdata = {6'b000000, want.key, want.action};
                if (o_m_tdata !== want_tdata || o_m_tlast !== want.last) begin
                    $display("%0t: mismatch: expected action=%0d key=%h last=%b, actual %s",
                             $time, want.action, want.key, want.last,
                             $sformatf("action=%0d key=%h last=%b zero=%h", o_m_tdata[1:0],
                                       o_m_tdata[9:2], o_m_tlast, o_m_tdata[15:10]));
                    mismatches++;
                end
            end
        end
    end

    initial begin
        cfg_sync_first  = RST_SYNC_FIRST;
        cfg_sync_second = RST_SYNC_SECOND;
        cfg_version     = RST_EXP_VERSION;
        cfg_max_payload = RST_MAX_PAYLOAD;
        cfg_timeout     = RST_TIMEOUT;
        dfm_state       = SEEK_FIRST;
        dfm_pos         = '0;
        dfm_len         = '0;
        dfm_crc         = '0;
        dfm_version     = '0;
        dfm_type        = '0;
        dfm_pay0        = '0;
        dfm_pay1        = '0;
        silence_ms      = '0;
        keys_held       = 1'b0;
        // Hold reset, then release it at a falling clock edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_key_events();
        test_key_state();
        test_rejected_frames();
        test_release_timeout();
        test_config_extremes();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
